[rtl/davg_pkg.sv]
package davg_pkg;

  // field widths
  localparam int SAMPLE_W = 10;
  localparam int SETTLE_W = 4;
  localparam int TICK_W   = 9;
  localparam int SEC_W    = 6;
  localparam int MIN_W    = 6;
  localparam int HOUR_W   = 5;
  localparam int MUX_W    = 2;

  // default ring depth
  localparam int DEFAULT_WINDOW = 10;

  // runtime clock limits
  localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(59);
  localparam logic [MIN_W-1:0]  MIN_LAST  = MIN_W'(59);
  localparam logic [HOUR_W-1:0] HOUR_LAST = HOUR_W'(23);

  // analog channel codes
  localparam logic [MUX_W-1:0] MUX_LOW  = MUX_W'(2);
  localparam logic [MUX_W-1:0] MUX_HIGH = MUX_W'(3);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_LIMIT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = CFG_IDX_W'(1);

  // register reset values
  localparam logic [SETTLE_W-1:0] SETTLE_LIMIT_RST     = SETTLE_W'(3);
  localparam logic [TICK_W-1:0]   TICKS_PER_SECOND_RST = TICK_W'(488);

  typedef struct packed {
    logic                conv_done;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic                start_conv;
    logic [MUX_W-1:0]    mux_channel;
    logic [SAMPLE_W-1:0] low_avg;
    logic [SAMPLE_W-1:0] high_avg;
    logic [SEC_W-1:0]    seconds;
    logic [MIN_W-1:0]    minutes;
    logic [HOUR_W-1:0]   hours;
  } result_t;

  typedef struct packed {
    logic [SEC_W-1:0]  seconds;
    logic [MIN_W-1:0]  minutes;
    logic [HOUR_W-1:0] hours;
  } rtc_time_t;

endpackage

[rtl/davg_ram.sv]
module davg_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/davg_ring.sv]
module davg_ring #(
  parameter int WINDOW = davg_pkg::DEFAULT_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [$clog2(WINDOW)-1:0]       wr_addr,
  input  logic [davg_pkg::SAMPLE_W-1:0]   wr_data,
  input  logic [$clog2(WINDOW)-1:0]       rd_addr,
  output logic [davg_pkg::SAMPLE_W-1:0]   avg_next
);
  import davg_pkg::*;

  localparam int IDX_W      = $clog2(WINDOW);
  localparam int SUM_W      = SAMPLE_W + IDX_W;
  localparam int DIV_SHIFT  = SUM_W + IDX_W;
  localparam int PROD_W     = 2 * SUM_W + 2;
  localparam int DIV_MUL_I  = (2 ** DIV_SHIFT + WINDOW - 1) / WINDOW;
  localparam logic [PROD_W-1:0] DIV_MUL = PROD_W'(DIV_MUL_I);

  logic [SAMPLE_W-1:0] ram_q;
  logic [WINDOW-1:0]   filled;
  logic                rd_ok;
  logic                fwd;
  logic [SAMPLE_W-1:0] fwd_data;
  logic [SAMPLE_W-1:0] old;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;
  logic [PROD_W-1:0]   prod;

  davg_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // entry valid bits and same-address forwarding around the ram
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      rd_ok  <= 1'b0;
      fwd    <= 1'b0;
    end else begin
      if (wr_en) begin
        filled[wr_addr] <= 1'b1;
      end
      rd_ok <= filled[rd_addr];
      fwd   <= wr_en && (wr_addr == rd_addr);
    end
    fwd_data <= wr_data;
  end

  // oldest entry at the prefetched index, zero until first written
  always_comb begin
    if (fwd) begin
      old = fwd_data;
    end else if (rd_ok) begin
      old = ram_q;
    end else begin
      old = '0;
    end
  end

  // running sum
  assign sum_next = wr_en ? (sum - SUM_W'(old) + SUM_W'(wr_data)) : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else begin
      sum <= sum_next;
    end
  end

  // divide by the window through a reciprocal multiply, exact over the sum range
  assign prod     = PROD_W'(sum_next) * DIV_MUL;
  assign avg_next = prod[DIV_SHIFT +: SAMPLE_W];

endmodule

[rtl/davg_rtc.sv]
module davg_rtc (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tick,
  input  logic [davg_pkg::TICK_W-1:0] ticks_per_second,
  output davg_pkg::rtc_time_t         time_next
);
  import davg_pkg::*;

  logic [TICK_W-1:0] tick_cnt;
  logic [TICK_W-1:0] tick_cnt_next;
  rtc_time_t         now;
  rtc_time_t         adv_time;
  logic              second_due;

  // second, minute and hour rollover
  always_comb begin
    second_due    = (tick_cnt == ticks_per_second);
    tick_cnt_next = second_due ? TICK_W'(1) : tick_cnt + TICK_W'(1);
    adv_time      = now;
    if (second_due) begin
      if (now.seconds == SEC_LAST) begin
        adv_time.seconds = '0;
        if (now.minutes == MIN_LAST) begin
          adv_time.minutes = '0;
          if (now.hours == HOUR_LAST) begin
            adv_time.hours = '0;
          end else begin
            adv_time.hours = now.hours + HOUR_W'(1);
          end
        end else begin
          adv_time.minutes = now.minutes + MIN_W'(1);
        end
      end else begin
        adv_time.seconds = now.seconds + SEC_W'(1);
      end
    end
    time_next = tick ? adv_time : now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_cnt <= '0;
      now      <= '0;
    end else if (tick) begin
      tick_cnt <= tick_cnt_next;
      now      <= adv_time;
    end
  end

`ifndef ASSERT_OFF
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    now.seconds <= SEC_LAST && now.minutes <= MIN_LAST && now.hours <= HOUR_LAST)
    else $error("runtime clock out of range");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !tick |=> $stable(now) && $stable(tick_cnt))
    else $error("runtime clock moved without a tick");

  a_second_step: assert property (@(posedge clk) disable iff (rst)
    tick && !second_due |=> $stable(now))
    else $error("time advanced before the second elapsed");
`endif

endmodule

[rtl/dual_channel_adc_averager_unit.sv]
// Dual-channel ADC averager. Each request on the item channel is one timer tick
// carrying the converter's done flag and a 10-bit sample; it yields exactly one
// request on the result channel with the conversion-start strobe, the selected
// analog channel, both ten-sample averages and the hh:mm:ss runtime clock, all
// as they stand after that tick. An accepted item is held in the input register
// and moves to the result register once that is free, so the block takes one
// item per cycle while the result channel does not stall. The sample rings live
// in a one-write, one-read RAM per channel; the read is issued ahead at the
// index the next tick will use, so the oldest sample is ready for it. Ring entries
// start at zero through per-entry valid bits, so no clearing pass follows reset.
// Configuration registers (settle_limit, ticks_per_second) are to be written only
// while idle; the block itself does not enforce this.
module dual_channel_adc_averager_unit #(
  parameter int WINDOW = davg_pkg::DEFAULT_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  davg_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output davg_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [davg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [davg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import davg_pkg::*;

  localparam int IDX_W = $clog2(WINDOW);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

  logic [SETTLE_W-1:0] settle_limit;
  logic [TICK_W-1:0]   ticks_per_second;

  logic                in_vld;
  item_t               in_item;
  logic                out_free;
  logic                adv;
  logic                accept;

  logic                channel;
  logic                channel_next;
  logic [SETTLE_W-1:0] settle_count;
  logic [SETTLE_W-1:0] settle_count_next;
  logic [IDX_W-1:0]    ring_index;
  logic [IDX_W-1:0]    ring_index_next;

  logic                take;
  logic                start_now;
  logic                wr_low;
  logic                wr_high;
  logic [SAMPLE_W-1:0] low_avg_next;
  logic [SAMPLE_W-1:0] high_avg_next;
  rtc_time_t           time_next;
  result_t             result_next;

  // handshake
  assign out_free   = !result_valid || !result_stall;
  assign adv        = in_vld && out_free;
  assign item_stall = in_vld && !out_free;
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_limit     <= SETTLE_LIMIT_RST;
      ticks_per_second <= TICKS_PER_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SETTLE_LIMIT:     settle_limit     <= cfg_data[SETTLE_W-1:0];
        REG_TICKS_PER_SECOND: ticks_per_second <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (accept) begin
      in_vld <= 1'b1;
    end else if (adv) begin
      in_vld <= 1'b0;
    end
    if (accept) begin
      in_item <= item;
    end
  end

  // settle count and sample sequencing
  always_comb begin
    take              = in_item.conv_done && (settle_count == '0);
    start_now         = in_item.conv_done && (settle_count != '0)
                        && (settle_count > settle_limit);
    settle_count_next = settle_count;
    channel_next      = channel;
    ring_index_next   = ring_index;
    if (adv && in_item.conv_done) begin
      if (take) begin
        settle_count_next = SETTLE_W'(1);
        channel_next      = !channel;
        if (channel) begin
          ring_index_next = (ring_index == IDX_LAST) ? '0 : ring_index + IDX_W'(1);
        end
      end else if (start_now) begin
        settle_count_next = '0;
      end else begin
        settle_count_next = settle_count + SETTLE_W'(1);
      end
    end
  end

  assign wr_low  = adv && take && !channel;
  assign wr_high = adv && take && channel;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel      <= 1'b0;
      settle_count <= '0;
      ring_index   <= '0;
    end else begin
      channel      <= channel_next;
      settle_count <= settle_count_next;
      ring_index   <= ring_index_next;
    end
  end

  // sample rings with running sums
  davg_ring #(
    .WINDOW (WINDOW)
  ) u_low_ring (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_low),
    .wr_addr  (ring_index),
    .wr_data  (in_item.sample),
    .rd_addr  (ring_index_next),
    .avg_next (low_avg_next)
  );

  davg_ring #(
    .WINDOW (WINDOW)
  ) u_high_ring (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_high),
    .wr_addr  (ring_index),
    .wr_data  (in_item.sample),
    .rd_addr  (ring_index_next),
    .avg_next (high_avg_next)
  );

  // runtime clock
  davg_rtc u_rtc (
    .clk              (clk),
    .rst              (rst),
    .tick             (adv),
    .ticks_per_second (ticks_per_second),
    .time_next        (time_next)
  );

  // result register
  always_comb begin
    result_next.start_conv  = start_now;
    result_next.mux_channel = channel_next ? MUX_HIGH : MUX_LOW;
    result_next.low_avg     = low_avg_next;
    result_next.high_avg    = high_avg_next;
    result_next.seconds     = time_next.seconds;
    result_next.minutes     = time_next.minutes;
    result_next.hours       = time_next.hours;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (adv) begin
      result <= result_next;
    end
  end

`ifndef ASSERT_OFF
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    ring_index <= IDX_LAST)
    else $error("ring index past window");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    adv && start_now |=> settle_count == '0)
    else $error("settle count not cleared on conversion start");

  a_sample_settles: assert property (@(posedge clk) disable iff (rst)
    adv && take |=> settle_count == SETTLE_W'(1) && channel != $past(channel))
    else $error("sample did not toggle channel and begin settling");

  a_no_toggle: assert property (@(posedge clk) disable iff (rst)
    !(adv && take) |=> $stable(channel) && $stable(ring_index))
    else $error("channel or index moved without a sample");
`endif

endmodule

[bench/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import davg_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int WINDOW = DEFAULT_WINDOW;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    bit      given;
    result_t value;
  } typed_result_t;

  // one directed tick, with its result typed in where it is obvious
  typedef struct {
    logic                conv_done;
    logic [SAMPLE_W-1:0] sample;
    bit                  given;
    logic                start_conv;
    logic [MUX_W-1:0]    mux_channel;
    logic [SAMPLE_W-1:0] low_avg;
    logic [SAMPLE_W-1:0] high_avg;
  } directed_tick_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  item_t                 item;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // averager state as the block should hold it
  logic [SETTLE_W-1:0] settle_limit_q = SETTLE_LIMIT_RST;
  logic [TICK_W-1:0]   tps_q = TICKS_PER_SECOND_RST;
  bit                  chan_high = 1'b0;
  logic [SETTLE_W-1:0] settle_cnt = '0;
  int                  ring_pos = 0;
  logic [SAMPLE_W-1:0] low_ring [WINDOW] = '{default: '0};
  logic [SAMPLE_W-1:0] high_ring [WINDOW] = '{default: '0};
  int                  low_total = 0;
  int                  high_total = 0;
  logic [TICK_W-1:0]   tick_cnt = '0;
  int                  rtc_sec = 0;
  int                  rtc_min = 0;
  int                  rtc_hour = 0;

  typed_result_t typed_results_q[$];
  result_t       expected_results[$];
  result_t       predicted;
  result_t       oldest;
  typed_result_t typed_entry;

  dual_channel_adc_averager_unit #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // one tick of the averager and runtime clock, returns the result it yields
  function automatic result_t advance_averager(item_t it);
    result_t r;
    r = '0;
    if (it.conv_done) begin
      if (settle_cnt != '0) begin
        // settling: start the next conversion once past the limit
        if (settle_cnt > settle_limit_q) begin
          r.start_conv = 1'b1;
          settle_cnt = '0;
        end else begin
          settle_cnt = settle_cnt + 1'b1;
        end
      end else begin
        // take the sample into the selected ring
        if (!chan_high) begin
          low_total = low_total - int'(low_ring[ring_pos]) + int'(it.sample);
          low_ring[ring_pos] = it.sample;
        end else begin
          high_total = high_total - int'(high_ring[ring_pos]) + int'(it.sample);
          high_ring[ring_pos] = it.sample;
          ring_pos = (ring_pos + 1) % WINDOW;
        end
        chan_high = !chan_high;
        settle_cnt = SETTLE_W'(1);
      end
    end
    // runtime clock
    if (tick_cnt == tps_q) begin
      tick_cnt = '0;
      rtc_sec++;
      if (rtc_sec > SEC_LAST) begin
        rtc_sec = 0;
        rtc_min++;
        if (rtc_min > MIN_LAST) begin
          rtc_min = 0;
          rtc_hour++;
          if (rtc_hour > HOUR_LAST) rtc_hour = 0;
        end
      end
    end
    tick_cnt = tick_cnt + 1'b1;
    r.mux_channel = chan_high ? MUX_HIGH : MUX_LOW;
    r.low_avg = SAMPLE_W'(low_total / WINDOW);
    r.high_avg = SAMPLE_W'(high_total / WINDOW);
    r.seconds = SEC_W'(rtc_sec);
    r.minutes = MIN_W'(rtc_min);
    r.hours = HOUR_W'(rtc_hour);
    return r;
  endfunction

  function automatic item_t random_tick();
    item_t it;
    it.conv_done = ($urandom_range(99) < 80);
    case ($urandom_range(9))
      0: it.sample = '0;
      1: it.sample = '1;
      default: it.sample = SAMPLE_W'($urandom_range(1023));
    endcase
    return it;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // present one tick request and hold it until taken
  task automatic send_tick(item_t it, bit given, result_t value);
    typed_result_t e;
    e.given = given;
    e.value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    typed_results_q.push_back(e);
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // let every outstanding result come back
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // new settings, written while the block is idle
  task automatic run_phase(logic [SETTLE_W-1:0] limit, logic [TICK_W-1:0] tps, int count);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= REG_SETTLE_LIMIT;
    cfg_data <= CFG_DATA_W'(limit);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_TICKS_PER_SECOND;
    cfg_data <= CFG_DATA_W'(tps);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    repeat (count) send_tick(random_tick(), 1'b0, '0);
  endtask

  // receiver stalls
  always @(posedge clk) result_stall <= ($urandom_range(99) < recv_idle_pct);

  // track config writes, predict on each tick request, check each result
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SETTLE_LIMIT) settle_limit_q = cfg_data[SETTLE_W-1:0];
        else if (cfg_index == REG_TICKS_PER_SECOND) tps_q = cfg_data[TICK_W-1:0];
      end
      if (item_valid && !item_stall) begin
        predicted = advance_averager(item);
        typed_entry = typed_results_q.pop_front();
        expected_results.push_back(typed_entry.given ? typed_entry.value : predicted);
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $error("result request with no expectation pending");
        end else begin
          oldest = expected_results.pop_front();
          check_field("start_conv", oldest.start_conv, result.start_conv);
          check_field("mux_channel", oldest.mux_channel, result.mux_channel);
          check_field("low_avg", oldest.low_avg, result.low_avg);
          check_field("high_avg", oldest.high_avg, result.high_avg);
          check_field("seconds", oldest.seconds, result.seconds);
          check_field("minutes", oldest.minutes, result.minutes);
          check_field("hours", oldest.hours, result.hours);
        end
      end
    end
  end

  // watchdog on cycles with no request taken anywhere
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    directed_tick_t directed_rows[];
    item_t          stim;
    result_t        want;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SETTLE_LIMIT;
    cfg_data = '0;

    // reset settings: settle limit 3, clock still at zero for these ticks
    directed_rows = '{
      '{1'b0, 10'd0,     1'b1, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b1, 10'd1023,  1'b1, 1'b0, MUX_HIGH, 10'd102, 10'd0},
      '{1'b1, 10'd0,     1'b1, 1'b0, MUX_HIGH, 10'd102, 10'd0},
      '{1'b1, 10'd0,     1'b1, 1'b0, MUX_HIGH, 10'd102, 10'd0},
      '{1'b1, 10'd0,     1'b1, 1'b0, MUX_HIGH, 10'd102, 10'd0},
      '{1'b1, 10'd5,     1'b1, 1'b1, MUX_HIGH, 10'd102, 10'd0},
      '{1'b1, 10'd1023,  1'b1, 1'b0, MUX_LOW,  10'd102, 10'd102},
      '{1'b0, 10'd1023,  1'b1, 1'b0, MUX_LOW,  10'd102, 10'd102},
      '{1'b1, 10'h155,   1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b1, 10'h2aa,   1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b1, 10'h3ff,   1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b1, 10'd0,     1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b1, 10'd1,     1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b1, 10'h200,   1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b0, 10'h155,   1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b1, 10'h2aa,   1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b1, 10'd0,     1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b1, 10'h3ff,   1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b1, 10'd1023,  1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b1, 10'd1,     1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b0, 10'd0,     1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0},
      '{1'b1, 10'd512,   1'b0, 1'b0, MUX_LOW,  10'd0,   10'd0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // sender idles a little, receiver a lot
    send_idle_pct = 16;
    recv_idle_pct = 52;
    foreach (directed_rows[n]) begin
      stim.conv_done = directed_rows[n].conv_done;
      stim.sample = directed_rows[n].sample;
      want = '0;
      want.start_conv = directed_rows[n].start_conv;
      want.mux_channel = directed_rows[n].mux_channel;
      want.low_avg = directed_rows[n].low_avg;
      want.high_avg = directed_rows[n].high_avg;
      send_tick(stim, directed_rows[n].given, want);
    end
    repeat (300) send_tick(random_tick(), 1'b0, '0);
    // no settling at all, a second on every tick
    run_phase(SETTLE_W'(0), TICK_W'(1), 250);

    // sender idles a lot, receiver a little
    send_idle_pct = 52;
    recv_idle_pct = 16;
    // settle count wraps to zero; tick counter wraps past 511
    run_phase(SETTLE_W'(15), TICK_W'(0), 400);
    run_phase(SETTLE_W'(15), TICK_W'(511), 350);

    // back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(SETTLE_W'($urandom_range(15)), TICK_W'($urandom_range(511, 1)), 150);
    // one second per tick, so seconds roll into minutes
    run_phase(SETTLE_W'($urandom_range(15)), TICK_W'(1), 228);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
